// ===== rtl/wfs_pkg.sv =====
// Package for the wall-follow steering block: wall class and event codes,
// register indexes and the 16-bit saturation helper. No dependencies.
package wfs_pkg;

    localparam int LevelWidth  = 12;
    localparam int RefWidth    = 16;
    localparam int GainWidth   = 16;
    localparam int CfgIdxWidth = 3;
    localparam int CfgDataWidth = 16;
    localparam int InDataWidth  = 64;
    localparam int OutDataWidth = 56;

    typedef logic [LevelWidth-1:0]      level_t;
    typedef logic signed [RefWidth-1:0] ref_t;
    typedef logic [1:0]                 code_t;

    localparam code_t ClassBoth  = 2'd0;
    localparam code_t ClassRight = 2'd1;
    localparam code_t ClassLeft  = 2'd2;
    localparam code_t ClassNone  = 2'd3;

    localparam code_t EvNone = 2'd0;
    localparam code_t EvIn   = 2'd1;
    localparam code_t EvOut  = 2'd2;

    localparam logic [CfgIdxWidth-1:0] RegRightKeep  = 3'd0;
    localparam logic [CfgIdxWidth-1:0] RegRightEnter = 3'd1;
    localparam logic [CfgIdxWidth-1:0] RegLeftKeep   = 3'd2;
    localparam logic [CfgIdxWidth-1:0] RegLeftEnter  = 3'd3;
    localparam logic [CfgIdxWidth-1:0] RegRightIdeal = 3'd4;
    localparam logic [CfgIdxWidth-1:0] RegLeftIdeal  = 3'd5;
    localparam logic [CfgIdxWidth-1:0] RegBalance    = 3'd6;
    localparam logic [CfgIdxWidth-1:0] RegGain       = 3'd7;

    localparam logic signed [LevelWidth-1:0] BalanceReset = 12'sd90;
    localparam logic [GainWidth-1:0]         GainReset    = 16'd256;

    function automatic ref_t sat16(input logic signed [31:0] v);
        ref_t r;
        if (v > 32'sd32767)
            r = 16'sh7fff;
        else if (v < -32'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    function automatic code_t classify(input logic r, input logic l);
        code_t c;
        if (r && l)
            c = ClassBoth;
        else if (r)
            c = ClassRight;
        else if (l)
            c = ClassLeft;
        else
            c = ClassNone;
        return c;
    endfunction

endpackage

// ===== rtl/wall_follow_steering_top.sv =====
// Top level of the wall-follow steering block: wall tracking with hysteresis,
// wall classification and steering correction with a Q8.8 gain. Depends on wfs_pkg.
//
// Usage: one request on the s_axis channel is one control tick; it yields
// exactly one request on the m_axis channel carrying both wheel targets, the
// steering correction, the wall class and the position event.
// The configuration port writes one register per cycle while cfg_we is high;
// it should only be written while no tick is in flight.
// The result passes an input register, a register after the gain multiplier and
// the result register before it appears on m_axis. One tick is accepted every
// cycle while the receiver does not stall; the wall flags are updated as a tick
// leaves the input register, so consecutive ticks see each other's flags.
// When the receiver stalls, the whole pipeline holds and s_axis_tready falls
// only while the result register is full and not being taken.
// Reset clears the pipeline, sets both wall flags to present, the balance
// offset to 90, the gain to 1.0 and the other registers to zero.
module wall_follow_steering_top
    import wfs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CfgIdxWidth-1:0]  cfg_index,
    input  logic [CfgDataWidth-1:0] cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // right_level, left_level, right_diag_wall, left_diag_wall, forward_ref,
    // turn_ref, stopped, zero padding
    input  logic [InDataWidth-1:0]  s_axis_tdata,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // left_target, right_target, correction, wall_class, position_event,
    // zero padding
    output logic [OutDataWidth-1:0] m_axis_tdata
);

    level_t                   right_keep_reg, right_enter_reg;
    level_t                   left_keep_reg, left_enter_reg;
    level_t                   right_ideal_reg, left_ideal_reg;
    logic signed [LevelWidth-1:0] balance_reg;
    logic [GainWidth-1:0]     gain_reg;

    logic right_wall_reg, left_wall_reg;
    logic right_wall_next, left_wall_next;

    logic                   s1_valid_reg;
    level_t                 s1_rl_reg, s1_ll_reg;
    logic                   s1_rdiag_reg, s1_ldiag_reg, s1_stop_reg;
    ref_t                   s1_fwd_reg, s1_turn_reg;

    logic                   s2_valid_reg;
    logic signed [30:0]     s2_prod_reg;
    ref_t                   s2_fwd_reg, s2_turn_reg;
    code_t                  s2_class_reg, s2_event_reg;

    logic                   out_valid_reg;
    ref_t                   out_left_reg, out_right_reg, out_corr_reg;
    code_t                  out_class_reg, out_event_reg;

    logic                   advance;
    logic                   active;
    logic                   nr, nl;
    logic                   r_change, l_change;
    code_t                  old_class, class_next, trig, event_next;
    logic signed [13:0]     err;
    logic signed [16:0]     gain_s;
    logic signed [30:0]     prod;
    logic signed [22:0]     prod_shift;
    ref_t                   corr;
    logic signed [17:0]     left_sum, right_sum;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            right_keep_reg  <= '0;
            right_enter_reg <= '0;
            left_keep_reg   <= '0;
            left_enter_reg  <= '0;
            right_ideal_reg <= '0;
            left_ideal_reg  <= '0;
            balance_reg     <= BalanceReset;
            gain_reg        <= GainReset;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                RegRightKeep:  right_keep_reg  <= cfg_data[LevelWidth-1:0];
                RegRightEnter: right_enter_reg <= cfg_data[LevelWidth-1:0];
                RegLeftKeep:   left_keep_reg   <= cfg_data[LevelWidth-1:0];
                RegLeftEnter:  left_enter_reg  <= cfg_data[LevelWidth-1:0];
                RegRightIdeal: right_ideal_reg <= cfg_data[LevelWidth-1:0];
                RegLeftIdeal:  left_ideal_reg  <= cfg_data[LevelWidth-1:0];
                RegBalance:    balance_reg     <= $signed(cfg_data[LevelWidth-1:0]);
                RegGain:       gain_reg        <= cfg_data[GainWidth-1:0];
                default:       ;
            endcase
        end
    end

    // Stage one: wall tracking, class, error and gain product.
    always_comb
    begin
        active    = !s1_stop_reg && (s1_fwd_reg > 16'sd0);
        old_class = classify(right_wall_reg, left_wall_reg);
        nr = s1_rl_reg > (right_wall_reg ? right_keep_reg : right_enter_reg);
        nl = s1_ll_reg > (left_wall_reg ? left_keep_reg : left_enter_reg);
        r_change = active && (nr != right_wall_reg) && (s1_rdiag_reg == nr);
        l_change = active && (nl != left_wall_reg) && (s1_ldiag_reg == nl);
        right_wall_next = r_change ? nr : right_wall_reg;
        left_wall_next  = l_change ? nl : left_wall_reg;
        trig = EvNone;
        if (r_change)
            trig = nr ? EvIn : EvOut;
        if (l_change)
            trig = nl ? EvIn : EvOut;
        class_next = classify(right_wall_next, left_wall_next);
        event_next = (class_next != old_class) ? trig : EvNone;
        err = '0;
        if (active)
        begin
            case (class_next)
                ClassBoth:  err = $signed({2'b00, s1_ll_reg}) - $signed({2'b00, s1_rl_reg})
                                  + 14'(balance_reg);
                ClassRight: err = $signed({2'b00, right_ideal_reg})
                                  - $signed({2'b00, s1_rl_reg});
                ClassLeft:  err = $signed({2'b00, s1_ll_reg})
                                  - $signed({2'b00, left_ideal_reg});
                default:    err = '0;
            endcase
        end
    end

    assign gain_s = $signed({1'b0, gain_reg});
    assign prod   = err * gain_s;

    // Stage two: floor shift, saturation and wheel targets.
    assign prod_shift = s2_prod_reg[30:8];
    assign corr       = sat16(32'(prod_shift));
    assign left_sum   = 18'(s2_fwd_reg) + 18'(corr) + 18'(s2_turn_reg);
    assign right_sum  = 18'(s2_fwd_reg) - 18'(corr) - 18'(s2_turn_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            right_wall_reg <= 1'b1;
            left_wall_reg  <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg  <= s_axis_tvalid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                right_wall_reg <= right_wall_next;
                left_wall_reg  <= left_wall_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_rl_reg    <= s_axis_tdata[11:0];
            s1_ll_reg    <= s_axis_tdata[23:12];
            s1_rdiag_reg <= s_axis_tdata[24];
            s1_ldiag_reg <= s_axis_tdata[25];
            s1_fwd_reg   <= s_axis_tdata[41:26];
            s1_turn_reg  <= s_axis_tdata[57:42];
            s1_stop_reg  <= s_axis_tdata[58];

            s2_prod_reg  <= prod;
            s2_fwd_reg   <= s1_fwd_reg;
            s2_turn_reg  <= s1_turn_reg;
            s2_class_reg <= class_next;
            s2_event_reg <= event_next;

            out_left_reg  <= sat16(32'(left_sum));
            out_right_reg <= sat16(32'(right_sum));
            out_corr_reg  <= corr;
            out_class_reg <= s2_class_reg;
            out_event_reg <= s2_event_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0000, out_event_reg, out_class_reg, out_corr_reg,
                            out_right_reg, out_left_reg};

    // An entering event leaves at least one wall; a leaving event cannot leave both.
    a_event_in_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg == EvIn) |-> (out_class_reg != ClassNone))
        else $error("wall entered but no wall reported");
    a_event_out_class: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_event_reg == EvOut) |-> (out_class_reg != ClassBoth))
        else $error("wall left but both walls reported");
    a_none_no_corr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_class_reg == ClassNone) |-> (out_corr_reg == 16'sd0))
        else $error("correction without a wall");
    a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && s1_valid_reg) |=> $stable(right_wall_reg) && $stable(left_wall_reg))
        else $error("wall flags changed without a tick");
    a_flags_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg && (event_next != EvNone) |=>
            (right_wall_reg != $past(right_wall_reg)) || (left_wall_reg != $past(left_wall_reg)))
        else $error("event without a flag change");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for wall_follow_steering_top: a directed table and then random
// ticks under several register settings, each result checked against a written value or a predictor.
// Depends on wfs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
    import wfs_pkg::*;

    typedef enum logic { RowTick, RowCfg } row_kind_t;

    typedef struct packed {
        level_t right_level;
        level_t left_level;
        logic   right_diag;
        logic   left_diag;
        ref_t   forward_ref;
        ref_t   turn_ref;
        logic   stopped;
    } tick_t;

    typedef struct packed {
        ref_t  left_target;
        ref_t  right_target;
        ref_t  correction;
        code_t wall_class;
        code_t position_event;
    } result_t;

    typedef struct {
        row_kind_t               kind;
        tick_t                   t;
        logic [CfgIdxWidth-1:0]  idx;
        logic [CfgDataWidth-1:0] data;
        bit                      typed;
        result_t                 want;
    } row_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CfgIdxWidth-1:0]  cfg_index = '0;
    logic [CfgDataWidth-1:0] cfg_data = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [InDataWidth-1:0]  s_axis_tdata = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    logic [OutDataWidth-1:0] m_axis_tdata;

    // Predictor copy of the registers and the wall flags.
    level_t              right_keep, right_enter, left_keep, left_enter;
    level_t              right_ideal, left_ideal;
    logic signed [11:0]  balance;
    logic [15:0]         steer_gain;
    logic                right_wall, left_wall;

    result_t pending_results[$];
    row_t    plan[$];
    logic [CfgIdxWidth-1:0] reg_list[8] = '{RegRightKeep, RegRightEnter, RegLeftKeep,
        RegLeftEnter, RegRightIdeal, RegLeftIdeal, RegBalance, RegGain};

    int ticks_sent = 0;
    int directed_ticks = 0;
    int results_seen = 0;
    int mismatches = 0;
    int settings_done = 0;
    int entries_seen = 0;
    int exits_seen = 0;
    int hold_req = 0;
    bit quiet = 1'b0;

    wall_follow_steering_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic ref_t clamp16(input longint v);
        ref_t r;
        if (v > 32767)
            r = 16'sh7fff;
        else if (v < -32768)
            r = 16'sh8000;
        else
            r = ref_t'(v);
        return r;
    endfunction

    function automatic code_t wall_code(input logic r, input logic l);
        code_t c;
        case ({r, l})
            2'b11:   c = ClassBoth;
            2'b10:   c = ClassRight;
            2'b01:   c = ClassLeft;
            default: c = ClassNone;
        endcase
        return c;
    endfunction

    function automatic void store_reg(input logic [CfgIdxWidth-1:0] idx,
                                      input logic [CfgDataWidth-1:0] data);
        case (idx)
            RegRightKeep:  right_keep  = data[11:0];
            RegRightEnter: right_enter = data[11:0];
            RegLeftKeep:   left_keep   = data[11:0];
            RegLeftEnter:  left_enter  = data[11:0];
            RegRightIdeal: right_ideal = data[11:0];
            RegLeftIdeal:  left_ideal  = data[11:0];
            RegBalance:    balance     = data[11:0];
            default:       steer_gain  = data;
        endcase
    endfunction

    // Updates the wall flags as the block does and returns the expected result.
    function automatic result_t steer_predict(input tick_t t);
        result_t r;
        code_t   was;
        code_t   trig;
        logic    nr, nl;
        longint  err, corr;
        corr = 0;
        r.position_event = EvNone;
        if (!t.stopped && t.forward_ref > 0) begin
            was  = wall_code(right_wall, left_wall);
            trig = EvNone;
            nr = t.right_level > (right_wall ? right_keep : right_enter);
            nl = t.left_level > (left_wall ? left_keep : left_enter);
            if (nr != right_wall && t.right_diag == nr) begin
                trig = nr ? EvIn : EvOut;
                right_wall = nr;
            end
            if (nl != left_wall && t.left_diag == nl) begin
                trig = nl ? EvIn : EvOut;
                left_wall = nl;
            end
            case (wall_code(right_wall, left_wall))
                ClassBoth:  err = longint'(t.left_level) - longint'(t.right_level)
                                  + longint'(balance);
                ClassRight: err = longint'(right_ideal) - longint'(t.right_level);
                ClassLeft:  err = longint'(t.left_level) - longint'(left_ideal);
                default:    err = 0;
            endcase
            corr = longint'(clamp16((err * longint'(steer_gain)) >>> 8));
            if (wall_code(right_wall, left_wall) != was)
                r.position_event = trig;
        end
        r.wall_class   = wall_code(right_wall, left_wall);
        r.correction   = clamp16(corr);
        r.left_target  = clamp16(longint'(t.forward_ref) + corr + longint'(t.turn_ref));
        r.right_target = clamp16(longint'(t.forward_ref) - corr - longint'(t.turn_ref));
        return r;
    endfunction

    function automatic row_t tick_row(input int rl, input int ll, input bit rd, input bit ld,
                                      input int fwd, input int turn, input bit stop);
        row_t r;
        r.kind  = RowTick;
        r.t.right_level = level_t'(rl);
        r.t.left_level  = level_t'(ll);
        r.t.right_diag  = rd;
        r.t.left_diag   = ld;
        r.t.forward_ref = ref_t'(fwd);
        r.t.turn_ref    = ref_t'(turn);
        r.t.stopped     = stop;
        r.idx   = '0;
        r.data  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CfgIdxWidth-1:0] idx,
                                     input logic [CfgDataWidth-1:0] data);
        row_t r;
        r = tick_row(0, 0, 0, 0, 0, 0, 0);
        r.kind = RowCfg;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic row_t with_result(input row_t r, input int lt, input int rt,
                                         input int c, input code_t cls, input code_t ev);
        r.typed = 1'b1;
        r.want.left_target    = ref_t'(lt);
        r.want.right_target   = ref_t'(rt);
        r.want.correction     = ref_t'(c);
        r.want.wall_class     = cls;
        r.want.position_event = ev;
        return r;
    endfunction

    function automatic level_t near_level(input level_t thr);
        int v;
        v = int'(thr) + int'($urandom_range(0, 8)) - 4;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return level_t'(v);
    endfunction

    function automatic tick_t rand_tick();
        tick_t t;
        int    pick;
        t.right_level = level_t'($urandom_range(0, 4095));
        t.left_level  = level_t'($urandom_range(0, 4095));
        if ($urandom_range(1))
            t.right_level = near_level($urandom_range(1) ? right_keep : right_enter);
        if ($urandom_range(1))
            t.left_level = near_level($urandom_range(1) ? left_keep : left_enter);
        t.right_diag = $urandom_range(1);
        t.left_diag  = $urandom_range(1);
        pick = $urandom_range(99);
        if (pick < 15)
            t.forward_ref = ref_t'(-int'($urandom_range(0, 32768)));
        else if (pick < 60)
            t.forward_ref = ref_t'($urandom_range(1, 2000));
        else
            t.forward_ref = ref_t'($urandom_range(1, 32767));
        if ($urandom_range(1))
            t.turn_ref = ref_t'(int'($urandom_range(0, 4000)) - 2000);
        else
            t.turn_ref = ref_t'($urandom_range(0, 65535));
        t.stopped = ($urandom_range(9) == 0);
        return t;
    endfunction

    function automatic logic [CfgDataWidth-1:0] setting_value(
        input logic [CfgIdxWidth-1:0] idx, input int mode);
        logic [CfgDataWidth-1:0] v;
        if (mode == 0)
            v = (idx == RegBalance) ? 16'h0800 : 16'h0000;
        else if (mode == 1)
            v = (idx == RegBalance) ? 16'h07ff : 16'hffff;
        else if (idx == RegGain && $urandom_range(7) != 0)
            v = 16'($urandom_range(0, 1023));
        else
            v = 16'($urandom_range(0, 65535));
        return v;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic release_bus();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CfgIdxWidth-1:0] idx,
                             input logic [CfgDataWidth-1:0] data);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        store_reg(idx, data);
    endtask

    // Offers one request and returns at the edge where it is taken.
    task automatic send_tick(input tick_t t, input bit typed, input result_t want);
        result_t guess;
        if (!quiet && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, t.stopped, t.turn_ref, t.forward_ref, t.left_diag,
                          t.right_diag, t.left_level, t.right_level};
        do
            @(posedge clk);
        while (!s_axis_tready);
        guess = steer_predict(t);
        pending_results.push_back(typed ? want : guess);
        ticks_sent++;
    endtask

    initial begin : stimulus
        int mode;
        right_keep  = '0;
        right_enter = '0;
        left_keep   = '0;
        left_enter  = '0;
        right_ideal = '0;
        left_ideal  = '0;
        balance     = BalanceReset;
        steer_gain  = GainReset;
        right_wall  = 1'b1;
        left_wall   = 1'b1;

        // Reset values first: inactive ticks, full-scale references, then flag changes.
        plan.push_back(with_result(tick_row(100, 200, 0, 0, 100, 5, 1),
                                   105, 95, 0, ClassBoth, EvNone));
        plan.push_back(with_result(tick_row(4095, 4095, 1, 1, 0, -7, 0),
                                   -7, 7, 0, ClassBoth, EvNone));
        plan.push_back(with_result(tick_row(0, 0, 1, 1, -32768, -32768, 0),
                                   -32768, 0, 0, ClassBoth, EvNone));
        plan.push_back(with_result(tick_row(0, 0, 1, 1, 32767, 32767, 0),
                                   32767, -90, 90, ClassBoth, EvNone));
        plan.push_back(tick_row(0, 0, 0, 1, 1, 0, 0));
        plan.push_back(tick_row(0, 0, 0, 0, 1, 0, 0));
        plan.push_back(tick_row(0, 0, 1, 1, 1, 0, 0));
        plan.push_back(tick_row(4095, 4095, 1, 1, 1000, -1000, 0));
        plan.push_back(tick_row(4095, 0, 1, 0, 1, 0, 0));
        plan.push_back(tick_row(0, 4095, 0, 1, 1, 0, 0));
        plan.push_back(cfg_row(RegRightKeep, 16'hffff));
        plan.push_back(cfg_row(RegRightEnter, 16'h0fff));
        plan.push_back(cfg_row(RegLeftKeep, 16'hffff));
        plan.push_back(cfg_row(RegLeftEnter, 16'h0fff));
        plan.push_back(cfg_row(RegBalance, 16'hf800));
        plan.push_back(cfg_row(RegGain, 16'hffff));
        plan.push_back(tick_row(4095, 4095, 1, 1, 32767, 0, 0));
        plan.push_back(tick_row(4095, 4095, 1, 0, 1, 0, 0));
        plan.push_back(cfg_row(RegRightEnter, 16'h0000));
        plan.push_back(cfg_row(RegLeftEnter, 16'h0000));
        plan.push_back(cfg_row(RegRightIdeal, 16'hffff));
        plan.push_back(cfg_row(RegLeftIdeal, 16'h0fff));
        plan.push_back(tick_row(1, 1, 1, 1, 1, 0, 0));
        plan.push_back(tick_row(4095, 0, 1, 1, -1, 3, 0));
        plan.push_back(tick_row(4095, 0, 0, 1, 20000, 20000, 0));
        plan.push_back(cfg_row(RegBalance, 16'h07ff));
        plan.push_back(cfg_row(RegGain, 16'h0000));
        plan.push_back(tick_row(4095, 4095, 1, 1, 500, -500, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            if (plan[i].kind == RowCfg) begin
                if (s_axis_tvalid)
                    release_bus();
                cfg_write(plan[i].idx, plan[i].data);
            end else begin
                send_tick(plan[i].t, plan[i].typed, plan[i].want);
                directed_ticks++;
            end
        end

        // Each setting waits for the pipeline to empty before the registers change.
        for (int phase = 0; phase < 8; phase++) begin
            if (s_axis_tvalid)
                release_bus();
            quiet = (phase == 2 || phase == 4);
            foreach (reg_list[k]) begin
                mode = (phase < 2) ? phase : $urandom_range(4);
                cfg_write(reg_list[k], setting_value(reg_list[k], mode));
            end
            settings_done++;
            if (phase == 4)
                hold_req = 60;
            repeat (100)
                send_tick(rand_tick(), 1'b0, '0);
        end

        release_bus();
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Run covered %0d ticks (%0d directed) over %0d random register settings,",
                 ticks_sent, directed_ticks, settings_done);
        $display("with %0d results checked, %0d wall entries and %0d wall exits.",
                 results_seen, entries_seen, exits_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial begin : result_side
        result_t got;
        result_t want;
        int      hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.left_target    = m_axis_tdata[15:0];
                got.right_target   = m_axis_tdata[31:16];
                got.correction     = m_axis_tdata[47:32];
                got.wall_class     = m_axis_tdata[49:48];
                got.position_event = m_axis_tdata[51:50];
                results_seen++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result request with no tick outstanding", $realtime);
                end else begin
                    want = pending_results.pop_front();
                    if (want.position_event == EvIn)
                        entries_seen++;
                    if (want.position_event == EvOut)
                        exits_seen++;
                    if (got.left_target !== want.left_target
                        || got.right_target !== want.right_target
                        || got.correction !== want.correction
                        || got.wall_class !== want.wall_class
                        || got.position_event !== want.position_event) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch, expected lt=%0d rt=%0d corr=%0d cls=%0d ",
                                      "ev=%0d, got lt=%0d rt=%0d corr=%0d cls=%0d ev=%0d"},
                                     $realtime, want.left_target, want.right_target,
                                     want.correction, want.wall_class, want.position_event,
                                     got.left_target, got.right_target, got.correction,
                                     got.wall_class, got.position_event);
                    end
                end
            end
            if (hold_left == 0 && hold_req != 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(99) >= 18);
            end
        end
    end

    initial begin : watchdog
        #2ms;
        $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wfs_pkg.sv
rtl/wall_follow_steering_top.sv
verif/tb_top.sv
